// File: sv/mfd_pkg.sv
// package for the monochrome frame store drawing block
// transaction mode codes and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package mfd_pkg;

  typedef logic [1:0] mfd_mode_t;

  localparam mfd_mode_t MODE_POINT = 2'd0;
  localparam mfd_mode_t MODE_RECT  = 2'd1;
  localparam mfd_mode_t MODE_CLEAR = 2'd2;
  localparam mfd_mode_t MODE_READ  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic start;     // load working registers, issue first store read
    logic rd;        // read the current column-page byte
    logic write;     // write back the merged byte
    logic advance;   // step to the next byte of the rectangle
    logic clr_step;  // write zero at the sweep address and step it
    logic load_out;  // load the result register
  } mfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rect_empty;  // incoming rectangle has zero width or height
    logic last_byte;   // current byte is the last of the item
    logic last_addr;   // sweep is at the last store address
  } mfd_sts_t;

endpackage

`default_nettype wire

// File: sv/mfd_item_if.sv
// input channel of the frame store block: handshake plus drawing transaction
// depends on nothing
`default_nettype none

interface mfd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic       color;
  logic [6:0] read_column;
  logic [2:0] read_page;

  modport source (
    output valid, mode, x, y, rect_width, rect_height, color, read_column, read_page,
    input  ready
  );
  modport sink (
    input  valid, mode, x, y, rect_width, rect_height, color, read_column, read_page,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/mfd_result_if.sv
// output channel of the frame store block: handshake plus read-back byte
// depends on nothing
`default_nettype none

interface mfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

// File: sv/mfd_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`default_nettype none

module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/mfd_datapath.sv
// datapath of the frame store block: byte addressing, pixel mask, merge,
// clear sweep counter, result register; instantiates mfd_ram, uses mfd_pkg
`default_nettype none

module mfd_datapath
  import mfd_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] x,
  input  wire logic [7:0] y,
  input  wire logic [7:0] rect_width,
  input  wire logic [7:0] rect_height,
  input  wire logic       color,
  input  wire logic [6:0] read_column,
  input  wire logic [2:0] read_page,
  input  wire mfd_cmd_t   cmd,
  output mfd_sts_t        sts,
  output logic [7:0]      read_data
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int ROWS  = PAGES * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [AW-1:0] PAGES_A  = AW'(PAGES);
  localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
  localparam logic [PW-1:0] LAST_PG  = PW'(PAGES - 1);

  // working registers
  logic [7:0]    col;
  logic [PW-1:0] page;
  logic [7:0]    icnt;
  logic [7:0]    ytop;
  logic [7:0]    hgt;
  logic          lit;
  logic          single;
  logic          is_read;
  logic          rd_ok;
  logic [AW-1:0] clr_addr;

  logic [PW-1:0] page_init;
  logic [4:0]    pt_page;
  logic          y_on;
  logic          rd_ok_in;
  logic [7:0]    sel_col;
  logic [PW-1:0] sel_page;
  logic [AW-1:0] byte_addr;
  logic          col_ok;
  logic          last_page;
  logic [3:0]    pinv;
  logic [7:0]    mask;
  logic [7:0]    rdata;
  logic [7:0]    merged;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  // page of a single point, flipped page order
  assign y_on    = {1'b0, y} < 9'(ROWS);
  assign pt_page = 5'(PAGES - 1) - y[7:3];
  assign rd_ok_in = ({2'b00, read_column} < 9'(COLUMNS)) && ({2'b00, read_page} < 5'(PAGES));

  always_comb begin
    unique case (mode)
      MODE_POINT: page_init = y_on ? PW'(pt_page) : '0;
      MODE_READ:  page_init = PW'({1'b0, read_page});
      default:    page_init = '0;
    endcase
  end

  // byte address: incoming item on start, working registers otherwise
  assign sel_col   = cmd.start ? ((mode == MODE_READ) ? {1'b0, read_column} : x) : col;
  assign sel_page  = cmd.start ? page_init : page;
  assign byte_addr = AW'(AW'(sel_col[CW-1:0]) * PAGES_A) + AW'(sel_page);

  assign col_ok    = {1'b0, col} < 9'(COLUMNS);
  assign last_page = single || (page == LAST_PG);

  // rows covered by the byte, bit 7 - k holds row 8 * (PAGES - 1 - page) + k
  assign pinv = 4'(PAGES - 1) - 4'(page);
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = 8'({1'b0, pinv, 3'(3'd7 - 3'(b))} - ytop) < hgt;
    end
  end

  assign merged = lit ? (rdata | mask) : (rdata & ~mask);

  // store write port: clear sweep or merged byte
  assign ram_we    = cmd.clr_step || (cmd.write && col_ok && (mask != 8'd0));
  assign ram_waddr = cmd.clr_step ? clr_addr : byte_addr;
  assign ram_wdata = cmd.clr_step ? 8'd0 : merged;

  mfd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.start || cmd.rd),
    .raddr (byte_addr),
    .rdata (rdata)
  );

  // working registers, loaded at start and stepped through the rectangle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col     <= sel_col;
      page    <= page_init;
      icnt    <= (mode == MODE_RECT) ? rect_width - 8'd1 : 8'd0;
      ytop    <= y;
      hgt     <= (mode == MODE_RECT) ? rect_height : 8'd1;
      lit     <= color;
      single  <= (mode != MODE_RECT);
      is_read <= (mode == MODE_READ);
      rd_ok   <= rd_ok_in;
    end else if (cmd.advance) begin
      if (last_page) begin
        col  <= col + 8'd1;
        icnt <= icnt - 8'd1;
        page <= '0;
      end else begin
        page <= PW'(page + 1'b1);
      end
    end
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= (clr_addr == LAST_A) ? '0 : AW'(clr_addr + 1'b1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data <= (is_read && rd_ok) ? rdata : 8'd0;
    end
  end

  assign sts.rect_empty = (rect_width == 8'd0) || (rect_height == 8'd0);
  assign sts.last_byte  = last_page && (icnt == 8'd0);
  assign sts.last_addr  = clr_addr == LAST_A;

endmodule

`default_nettype wire

// File: sv/mfd_ctrl.sv
// controller of the frame store block: sequences read-modify-write, clear
// sweeps and read-back, owns the handshakes; uses mfd_pkg
`default_nettype none

module mfd_ctrl
  import mfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_mode,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire mfd_sts_t   sts,
  output mfd_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_RDOUT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       boot;
  logic       boot_next;
  logic       out_valid_next;
  logic       out_free;
  logic       finish;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    boot_next  = boot;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          unique case (in_mode)
            MODE_POINT: state_next = S_WR;
            MODE_RECT:  state_next = sts.rect_empty ? S_FIN : S_WR;
            MODE_CLEAR: state_next = S_CLR;
            MODE_READ:  state_next = S_RDOUT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        cmd.write = 1'b1;
        if (sts.last_byte) begin
          finish = 1'b1;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.last_addr) begin
          if (boot) begin
            boot_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_RDOUT: finish = 1'b1;
      S_FIN:   finish = 1'b1;
      default: state_next = S_IDLE;
    endcase
    // hand the result over, or hold it until the output register frees
    if (finish) begin
      if (out_free) begin
        cmd.load_out = 1'b1;
        state_next   = S_IDLE;
      end else begin
        state_next = S_FIN;
      end
    end
  end

  assign out_valid_next = cmd.load_out || (out_valid && !out_ready);

  // state registers, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      boot      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      boot      <= boot_next;
      out_valid <= out_valid_next;
    end
  end

  // result register is only overwritten once it is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending transaction");

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted transaction left no work");

  // staying in the finish wait only happens behind an occupied output
  a_fin_blocked: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && !cmd.load_out) |-> out_valid)
    else $error("finish wait without pending result");

  // no merged-byte writes, result loads or item acceptance during the reset clearing pass
  a_boot_quiet: assert property (@(posedge clk) disable iff (rst)
    boot |-> (!cmd.load_out && !cmd.write && !in_ready))
    else $error("activity during reset clearing pass");

endmodule

`default_nettype wire

// File: sv/monochrome_framebuffer_draw.sv
// Page-mode monochrome frame store with drawing and read-back.
// Channels: item (sink) carries one drawing transaction: mode, x, y,
// rect_width, rect_height, color, read_column, read_page. result (source)
// returns exactly one read_data byte per transaction, zero except for reads.
// Both use valid/ready; a transaction moves when both are high at a clock edge.
// Steps per transaction, from acceptance to result loaded:
//   point: store read, then merged write; read: store read, then result load
//   clear: all COLUMNS*PAGES store bytes, one store byte zeroed per cycle
//   rectangle: a read-modify-write per column-page byte over rect_width columns
//   by PAGES pages, each on the single store write port
// Only one transaction is worked on at a time; the next is accepted in the
// cycle after its predecessor's result is loaded.
// Reset: synchronous rst runs a clearing pass over all COLUMNS*PAGES bytes (1024
// at default sizes) with item.ready low; no result is produced for it.
// A stalled receiver holds the result register; the block finishes the
// following transaction and then waits with item.ready low until it drains.
`default_nettype none

module monochrome_framebuffer_draw
  import mfd_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input wire logic clk,
  input wire logic rst,
  mfd_item_if.sink     item,
  mfd_result_if.source result
);

  mfd_cmd_t cmd;
  mfd_sts_t sts;
  logic     item_ready;
  logic     result_valid;
  logic [7:0] read_data;

  // sequencer
  mfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_mode   (item.mode),
    .in_ready  (item_ready),
    .out_valid (result_valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store and byte arithmetic
  mfd_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .mode        (item.mode),
    .x           (item.x),
    .y           (item.y),
    .rect_width  (item.rect_width),
    .rect_height (item.rect_height),
    .color       (item.color),
    .read_column (item.read_column),
    .read_page   (item.read_page),
    .cmd         (cmd),
    .sts         (sts),
    .read_data   (read_data)
  );

  assign item.ready       = item_ready;
  assign result.valid     = result_valid;
  assign result.read_data = read_data;

endmodule

`default_nettype wire
